@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of the blit address generator.
// Expects signals named clock and reset in scope; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clock, switched off while reset is high
`define SCB_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Concurrent assertion on clock that also holds through reset
`define SCB_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ sv/scb_pkg.sv @@
// Package for the scaled, clipped blit address generator: widths, codes,
// payload structs and controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scb_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int EXT_BITS   = COORD_BITS + 2;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
   localparam int DIV_BITS   = SIZE_BITS + FRAC_BITS;
   localparam int PROD_BITS  = COORD_BITS + ACC_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = SIZE_BITS;

   // Item command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLIP_LEFT   = 2'd0,
      CSR_CLIP_TOP    = 2'd1,
      CSR_CLIP_WIDTH  = 2'd2,
      CSR_CLIP_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 cmd;
      logic [COORD_BITS-1:0] dest_left;
      logic [COORD_BITS-1:0] dest_top;
      logic [SIZE_BITS-1:0]  dest_width;
      logic [SIZE_BITS-1:0]  dest_height;
      logic [SIZE_BITS-1:0]  source_width;
      logic [SIZE_BITS-1:0]  source_height;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] out_dest_x;
      logic [COORD_BITS-1:0] out_dest_y;
      logic [COORD_BITS-1:0] out_source_x;
      logic [COORD_BITS-1:0] out_source_y;
      logic                  last_pixel;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RUN,
      ST_DIVX_GO,
      ST_DIVX_WAIT,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_OFS_X,
      ST_OFS_Y,
      ST_SETUP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_sel_y;
      logic cap_step_x;
      logic cap_step_y;
      logic ofs_x;
      logic ofs_y;
      logic setup;
      logic advance;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic run_ok;
      logic step_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ sv/scb_div.sv @@
// Restoring divider, one quotient bit per cycle: ({num, FRAC zeros}) / den.
// Depends on scb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scb_div
   import scb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [SIZE_BITS-1:0] num,
   input  wire logic [SIZE_BITS-1:0] den,
   output logic                      done,
   output logic [ACC_BITS-1:0]       quot
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SIZE_BITS-1:0] rem_ff, rem_in;
   logic [SIZE_BITS-1:0] den_ff, den_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [SIZE_BITS:0]   trial;
   logic                 fits;

   // One trial subtraction per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_BITS-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIV_BITS);
         rem_in  = '0;
         den_in  = den;
         quo_in  = {num, {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         rem_in = fits ? SIZE_BITS'(trial - {1'b0, den_ff}) : trial[SIZE_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff[ACC_BITS-1:0];

endmodule

`default_nettype wire

@@ sv/scb_ctrl.sv @@
// Controller: sequences start set-up (divides, clip offsets) and pixel stepping.
// Depends on scb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scb_ctrl
   import scb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_cmd,
   output logic               req_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      can_take;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      can_take  = ((state_ff == ST_IDLE) || (state_ff == ST_RUN)) && status.out_free;
      take      = req_valid && can_take;
      req_stall = !can_take;
      cmd       = '0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // drop step items while no blit runs
            if (take && (req_cmd == CMD_START)) begin
               cmd.load = 1'b1;
               state_in = ST_DIVX_GO;
            end
         end
         ST_RUN: begin
            if (take) begin
               if (req_cmd == CMD_START) begin
                  cmd.load = 1'b1;
                  state_in = ST_DIVX_GO;
               end else begin
                  cmd.advance = 1'b1;
                  if (status.step_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_DIVX_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVX_WAIT;
         end
         ST_DIVX_WAIT: begin
            if (status.div_done) begin
               cmd.cap_step_x = 1'b1;
               state_in       = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in      = ST_DIVY_WAIT;
         end
         ST_DIVY_WAIT: begin
            cmd.div_sel_y = 1'b1;
            if (status.div_done) begin
               cmd.cap_step_y = 1'b1;
               state_in       = ST_OFS_X;
            end
         end
         ST_OFS_X: begin
            cmd.ofs_x = 1'b1;
            state_in  = ST_OFS_Y;
         end
         ST_OFS_Y: begin
            cmd.ofs_y = 1'b1;
            state_in  = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.run_ok ? ST_RUN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/scb_dpath.sv @@
// Datapath: clip registers, start latch, step divider, offset multiplier,
// cursors, accumulators and the result register. Depends on scb_pkg and scb_div.
`timescale 1ns / 1ps
`default_nettype none

module scb_dpath
   import scb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire req_type                   req_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                      rsp_stall,
   output logic                           rsp_valid,
   output rsp_type                        rsp_data,
   input  wire dp_cmd_type                cmd,
   output dp_status_type                  status
);

   // Configuration registers
   logic [COORD_BITS-1:0] clip_left_ff, clip_top_ff;
   logic [SIZE_BITS-1:0]  clip_width_ff, clip_height_ff;

   // Start snapshot
   logic [COORD_BITS-1:0] dl_ff, dt_ff, cl_ff, ct_ff;
   logic [SIZE_BITS-1:0]  dw_ff, dh_ff, sw_ff, sh_ff, cw_ff, ch_ff;

   // Blit state
   logic [ACC_BITS-1:0]   step_x_ff, step_y_ff, sx_ff, sy_ff;
   logic [SIZE_BITS-1:0]  cursor_x_ff, cursor_y_ff, row_first_x_ff;
   logic [SIZE_BITS-1:0]  row_end_x_ff, column_end_y_ff;
   logic [ACC_BITS-1:0]   row_src_x_ff, src_x_acc_ff, src_y_acc_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   // Divider operands
   logic [SIZE_BITS-1:0]  div_src, div_dst, div_num, div_den;
   logic                  div_done;
   logic [ACC_BITS-1:0]   div_quot;

   // Offset multiply
   logic [COORD_BITS-1:0] ofs_dx, ofs_dy, mul_a;
   logic [ACC_BITS-1:0]   mul_b;
   logic [PROD_BITS-1:0]  product;

   // Clipped rectangle
   logic [COORD_BITS-1:0] xs, ys;
   logic [EXT_BITS-1:0]   xe_raw, ye_raw, cr, cb, xe, ye;

   // Stepping
   logic [SIZE_BITS-1:0]  nx, ny;
   logic                  row_done, blit_done;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= SIZE_BITS'(1 << COORD_BITS);
         clip_height_ff <= SIZE_BITS'(1 << COORD_BITS);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata[COORD_BITS-1:0];
            CSR_CLIP_WIDTH:  clip_width_ff  <= csr_wdata;
            CSR_CLIP_HEIGHT: clip_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Select divide axis; source size zero counts as one
   always_comb begin
      div_src = cmd.div_sel_y ? sh_ff : sw_ff;
      div_dst = cmd.div_sel_y ? dh_ff : dw_ff;
      div_num = (div_src == '0) ? '0 : div_src - SIZE_BITS'(1);
      div_den = div_dst - SIZE_BITS'(1);
   end

   scb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Clip offsets and the shared multiplier
   always_comb begin
      ofs_dx  = (cl_ff > dl_ff) ? cl_ff - dl_ff : '0;
      ofs_dy  = (ct_ff > dt_ff) ? ct_ff - dt_ff : '0;
      mul_a   = cmd.ofs_y ? ofs_dy : ofs_dx;
      mul_b   = cmd.ofs_y ? step_y_ff : step_x_ff;
      product = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   // Clip the rectangle against the snapshot window
   always_comb begin
      xs     = (cl_ff > dl_ff) ? cl_ff : dl_ff;
      ys     = (ct_ff > dt_ff) ? ct_ff : dt_ff;
      xe_raw = EXT_BITS'(dl_ff) + EXT_BITS'(dw_ff);
      ye_raw = EXT_BITS'(dt_ff) + EXT_BITS'(dh_ff);
      cr     = EXT_BITS'(cl_ff) + EXT_BITS'(cw_ff);
      cb     = EXT_BITS'(ct_ff) + EXT_BITS'(ch_ff);
      xe     = (xe_raw > cr) ? cr : xe_raw;
      ye     = (ye_raw > cb) ? cb : ye_raw;
   end

   // Row and blit end detection
   always_comb begin
      nx        = cursor_x_ff + SIZE_BITS'(1);
      ny        = cursor_y_ff + SIZE_BITS'(1);
      row_done  = (nx == row_end_x_ff);
      blit_done = row_done && (ny == column_end_y_ff);
   end

   // Snapshot, set-up and stepping registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dl_ff <= req_data.dest_left;
         dt_ff <= req_data.dest_top;
         dw_ff <= req_data.dest_width;
         dh_ff <= req_data.dest_height;
         sw_ff <= req_data.source_width;
         sh_ff <= req_data.source_height;
         cl_ff <= clip_left_ff;
         ct_ff <= clip_top_ff;
         cw_ff <= clip_width_ff;
         ch_ff <= clip_height_ff;
      end
      if (cmd.cap_step_x) begin
         step_x_ff <= (dw_ff <= SIZE_BITS'(1)) ? '0 : div_quot;
      end
      if (cmd.cap_step_y) begin
         step_y_ff <= (dh_ff <= SIZE_BITS'(1)) ? '0 : div_quot;
      end
      if (cmd.ofs_x) begin
         sx_ff <= product[ACC_BITS-1:0];
      end
      if (cmd.ofs_y) begin
         sy_ff <= product[ACC_BITS-1:0];
      end
      if (cmd.setup) begin
         row_first_x_ff  <= SIZE_BITS'(xs);
         row_end_x_ff    <= xe[SIZE_BITS-1:0];
         column_end_y_ff <= ye[SIZE_BITS-1:0];
         cursor_x_ff     <= SIZE_BITS'(xs);
         cursor_y_ff     <= SIZE_BITS'(ys);
         row_src_x_ff    <= sx_ff;
         src_x_acc_ff    <= sx_ff;
         src_y_acc_ff    <= sy_ff;
      end else if (cmd.advance) begin
         if (row_done) begin
            if (!blit_done) begin
               cursor_y_ff  <= ny;
               cursor_x_ff  <= row_first_x_ff;
               src_x_acc_ff <= row_src_x_ff;
               src_y_acc_ff <= src_y_acc_ff + step_y_ff;
            end
         end else begin
            cursor_x_ff  <= nx;
            src_x_acc_ff <= src_x_acc_ff + step_x_ff;
         end
      end
   end

   // Result register: load on a step, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.advance) begin
         rsp_data_ff.out_dest_x   <= cursor_x_ff[COORD_BITS-1:0];
         rsp_data_ff.out_dest_y   <= cursor_y_ff[COORD_BITS-1:0];
         rsp_data_ff.out_source_x <= src_x_acc_ff[ACC_BITS-1:FRAC_BITS];
         rsp_data_ff.out_source_y <= src_y_acc_ff[ACC_BITS-1:FRAC_BITS];
         rsp_data_ff.last_pixel   <= blit_done;
      end
   end

   always_comb begin
      status.div_done  = div_done;
      status.run_ok    = (EXT_BITS'(xs) < xe) && (EXT_BITS'(ys) < ye);
      status.step_last = blit_done;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/scaled_clipped_blit_address_gen_unit.sv @@
// Top level of the scaled, clipped blit address generator.
// Depends on scb_pkg, scb_ctrl and scb_dpath.
//
//   port group  direction  payload    handshake
//   req_        in         req_type   req_valid / req_stall
//   rsp_        out        rsp_type   rsp_valid / rsp_stall
//   csr_        in         13-bit     csr_wr_en, csr_index (no wait)
//
// Step items follow back to back while results drain. A start item stalls req_
// until its set-up is done: the x and y divides (launch, 29 quotient bits, capture),
// the x and y offset multiplies and the set-up step.
// Reset is synchronous: the clip window returns to 0,0,4096,4096 and no blit runs.
// A stalled result is held in the output register; one more step is taken
// while it waits only if it is being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module scaled_clipped_blit_address_gen_unit
   import scb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   scb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   scb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

endmodule

`default_nettype wire

@@ sv/scb_checker.sv @@
// Port-level checks for the blit address generator, bound to the top level.
// Depends on scb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scb_checker
   import scb_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   logic req_take, step_take, start_take, rsp_wait;

   // Decode the handshakes
   assign req_take   = req_valid && !req_stall;
   assign step_take  = req_take && (req_data.cmd == CMD_STEP);
   assign start_take = req_take && (req_data.cmd == CMD_START);
   assign rsp_wait   = rsp_valid && rsp_stall;

   // A stalled result holds
   `SCB_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // A new result only follows an accepted step item
   `SCB_ASSERT(a_rsp_cause, $rose(rsp_valid) |-> $past(step_take), "result without a step item")

   // A start item blocks further items while set-up runs
   `SCB_ASSERT(a_start_busy, start_take |=> req_stall, "item taken during set-up")

   // Reset empties the result register
   `SCB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind scaled_clipped_blit_address_gen_unit scb_checker u_scb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

@@ tb/tb_scaled_clipped_blit_address_gen_unit.sv @@
// Self-checking bench for the scaled, clipped blit address generator: directed and
// random blits under several clip windows, with random gaps on both channels.
// Depends on scb_pkg and scaled_clipped_blit_address_gen_unit.
`timescale 1ns / 1ps

module tb_scaled_clipped_blit_address_gen_unit;
   import scb_pkg::*;

   // Tracks clip window and blit state, and queues the pixels each item produces
   class blit_scoreboard;
      bit [COORD_BITS-1:0] clip_left, clip_top;
      bit [SIZE_BITS-1:0]  clip_width, clip_height;
      bit                  running;
      bit [SIZE_BITS-1:0]  cur_x, cur_y, first_x, end_x, end_y;
      bit [ACC_BITS-1:0]   step_x, step_y, row_sx, acc_x, acc_y;
      rsp_type             expected_pixels[$];
      int                  errors;

      function new();
         clip_left   = '0;
         clip_top    = '0;
         clip_width  = SIZE_BITS'(1 << COORD_BITS);
         clip_height = SIZE_BITS'(1 << COORD_BITS);
         running     = 1'b0;
         errors      = 0;
      endfunction

      function void set_clip(csr_index_type idx, bit [CSR_DATA_BITS-1:0] v);
         case (idx)
            CSR_CLIP_LEFT:   clip_left   = v[COORD_BITS-1:0];
            CSR_CLIP_TOP:    clip_top    = v[COORD_BITS-1:0];
            CSR_CLIP_WIDTH:  clip_width  = v[SIZE_BITS-1:0];
            CSR_CLIP_HEIGHT: clip_height = v[SIZE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Source advance per destination pixel; a size of zero counts as one
      function bit [ACC_BITS-1:0] scale_step(bit [SIZE_BITS-1:0] src, bit [SIZE_BITS-1:0] dst);
         bit [63:0] num, q;
         num = (src != 0) ? 64'(src) - 64'd1 : 64'd0;
         if (dst <= 1) return '0;
         q = (num << FRAC_BITS) / (64'(dst) - 64'd1);
         return q[ACC_BITS-1:0];
      endfunction

      function void note_item(req_type r);
         bit [EXT_BITS-1:0] xs, xe, ys, ye, right_edge, bottom_edge;
         bit [63:0]         ofs;
         bit [SIZE_BITS-1:0] nx, ny;
         rsp_type           px;
         if (r.cmd == CMD_START) begin
            xs = EXT_BITS'(r.dest_left);
            ys = EXT_BITS'(r.dest_top);
            xe = EXT_BITS'(r.dest_left) + EXT_BITS'(r.dest_width);
            ye = EXT_BITS'(r.dest_top) + EXT_BITS'(r.dest_height);
            right_edge  = EXT_BITS'(clip_left) + EXT_BITS'(clip_width);
            bottom_edge = EXT_BITS'(clip_top) + EXT_BITS'(clip_height);
            step_x = scale_step(r.source_width, r.dest_width);
            step_y = scale_step(r.source_height, r.dest_height);
            acc_x = '0;
            acc_y = '0;
            // advance the source start by the clipped-off offset
            if (EXT_BITS'(clip_left) > xs) begin
               ofs   = 64'(EXT_BITS'(clip_left) - xs) * 64'(step_x);
               acc_x = ofs[ACC_BITS-1:0];
               xs    = EXT_BITS'(clip_left);
            end
            if (EXT_BITS'(clip_top) > ys) begin
               ofs   = 64'(EXT_BITS'(clip_top) - ys) * 64'(step_y);
               acc_y = ofs[ACC_BITS-1:0];
               ys    = EXT_BITS'(clip_top);
            end
            if (xe > right_edge) xe = right_edge;
            if (ye > bottom_edge) ye = bottom_edge;
            first_x = xs[SIZE_BITS-1:0];
            end_x   = xe[SIZE_BITS-1:0];
            end_y   = ye[SIZE_BITS-1:0];
            cur_x   = first_x;
            cur_y   = ys[SIZE_BITS-1:0];
            row_sx  = acc_x;
            running = (xs < xe) && (ys < ye);
         end else if (running) begin
            px.out_dest_x   = cur_x[COORD_BITS-1:0];
            px.out_dest_y   = cur_y[COORD_BITS-1:0];
            px.out_source_x = acc_x[ACC_BITS-1:FRAC_BITS];
            px.out_source_y = acc_y[ACC_BITS-1:FRAC_BITS];
            px.last_pixel   = 1'b0;
            nx = cur_x + 1'b1;
            if (nx == end_x) begin
               ny = cur_y + 1'b1;
               if (ny == end_y) begin
                  px.last_pixel = 1'b1;
                  running       = 1'b0;
               end else begin
                  // wrap to the start of the next row
                  cur_y = ny;
                  cur_x = first_x;
                  acc_x = row_sx;
                  acc_y = acc_y + step_y;
               end
            end else begin
               cur_x = nx;
               acc_x = acc_x + step_x;
            end
            expected_pixels.push_back(px);
         end
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel, expected none, got %h", $time, got);
            return;
         end
         want = expected_pixels.pop_front();
         check_field("out_dest_x", 32'(want.out_dest_x), 32'(got.out_dest_x));
         check_field("out_dest_y", 32'(want.out_dest_y), 32'(got.out_dest_y));
         check_field("out_source_x", 32'(want.out_source_x), 32'(got.out_source_x));
         check_field("out_source_y", 32'(want.out_source_y), 32'(got.out_source_y));
         check_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   csr_index_type             csr_index = CSR_CLIP_LEFT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   blit_scoreboard sb = new();
   int             item_count = 0;
   int             phase;

   scaled_clipped_blit_address_gen_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_req(logic cmd, int dl, int dt, int dw, int dh, int sw,
                                        int sh);
      req_type r;
      r.cmd           = cmd;
      r.dest_left     = COORD_BITS'(dl);
      r.dest_top      = COORD_BITS'(dt);
      r.dest_width    = SIZE_BITS'(dw);
      r.dest_height   = SIZE_BITS'(dh);
      r.source_width  = SIZE_BITS'(sw);
      r.source_height = SIZE_BITS'(sh);
      return r;
   endfunction

   // Step items carry random don't-care fields
   function automatic req_type step_req();
      return make_req(CMD_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4096), $urandom_range(0, 4096),
                      $urandom_range(0, 4096), $urandom_range(0, 4096));
   endfunction

   function automatic int coord_clamp(int v);
      if (v < 0) return 0;
      if (v > 4095) return 4095;
      return v;
   endfunction

   function automatic int source_size();
      if ($urandom_range(0, 39) == 0) return 0;
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, 20);
      return $urandom_range(1, 4096);
   endfunction

   // Start item: mostly small rectangles straddling a clip edge, some anywhere
   function automatic req_type random_start();
      int mode, x, y, w, h;
      mode = $urandom_range(0, 9);
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
      w = $urandom_range(1, 4096);
      h = $urandom_range(1, 4096);
      if (mode >= 2) begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 16);
         if (mode < 6) begin
            x = coord_clamp(int'(sb.clip_left) + $urandom_range(0, 24) - 16);
            y = coord_clamp(int'(sb.clip_top) + $urandom_range(0, 24) - 16);
         end else begin
            x = coord_clamp(int'(sb.clip_left) + int'(sb.clip_width) - $urandom_range(0, 20));
            y = coord_clamp(int'(sb.clip_top) + int'(sb.clip_height) - $urandom_range(0, 20));
         end
      end
      if ($urandom_range(0, 39) == 0) w = 0;
      if ($urandom_range(0, 39) == 0) h = 0;
      return make_req(CMD_START, x, y, w, h, source_size(), source_size());
   endfunction

   // Present one item, hold it until taken, then record it
   task automatic send_item(req_type r);
      int n;
      n = gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
   endtask

   // Drop valid, drain all pixels, and let a trailing start finish its divides
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_clip(int l, int t, int w, int h);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CLIP_LEFT;
      csr_wdata <= CSR_DATA_BITS'(l);
      @(posedge clock);
      sb.set_clip(CSR_CLIP_LEFT, CSR_DATA_BITS'(l));
      csr_index <= CSR_CLIP_TOP;
      csr_wdata <= CSR_DATA_BITS'(t);
      @(posedge clock);
      sb.set_clip(CSR_CLIP_TOP, CSR_DATA_BITS'(t));
      csr_index <= CSR_CLIP_WIDTH;
      csr_wdata <= CSR_DATA_BITS'(w);
      @(posedge clock);
      sb.set_clip(CSR_CLIP_WIDTH, CSR_DATA_BITS'(w));
      csr_index <= CSR_CLIP_HEIGHT;
      csr_wdata <= CSR_DATA_BITS'(h);
      @(posedge clock);
      sb.set_clip(CSR_CLIP_HEIGHT, CSR_DATA_BITS'(h));
      csr_wr_en <= 1'b0;
   endtask

   task automatic directed_blits();
      // step while idle gives nothing
      send_item(step_req());
      // single pixel, widest source: step forced to zero
      send_item(make_req(CMD_START, 0, 0, 1, 1, 4096, 4096));
      send_item(step_req());
      send_item(step_req());
      // far corner, widest rectangle trimmed by the window
      send_item(make_req(CMD_START, 4095, 4095, 4096, 4096, 1, 1));
      send_item(step_req());
      send_item(step_req());
      // empty rectangle
      send_item(make_req(CMD_START, 7, 9, 0, 0, 5, 5));
      send_item(step_req());
      // zero source size
      send_item(make_req(CMD_START, 10, 20, 3, 2, 0, 0));
      repeat (6) send_item(step_req());
      // large blit abandoned by a new start
      send_item(make_req(CMD_START, 0, 0, 4096, 4096, 4096, 4096));
      repeat (2) send_item(step_req());
      send_item(make_req(CMD_START, 4094, 100, 2, 2, 4096, 13));
      repeat (4) send_item(step_req());
   endtask

   // Blits with random content; most run to their last pixel, some are cut short
   task automatic random_blits(int budget);
      int goal, cap, taken;
      goal = item_count + budget;
      while (item_count < goal) begin
         send_item(random_start());
         item_count++;
         cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : 400;
         taken = 0;
         while (sb.running && taken < cap) begin
            send_item(step_req());
            taken++;
            item_count++;
         end
         repeat ($urandom_range(0, 2)) send_item(step_req());
      end
   endtask

   // Random back-pressure on the result side
   initial begin
      int n;
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         n = gap_length();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // Check every pixel taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_data);
   end

   initial begin
      int p;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_blits();
      phase = 0;
      while (item_count < 2000) begin
         settle();
         case (phase)
            0: write_clip(0, 0, 4096, 4096);
            1: write_clip(0, 0, 0, 0);
            2: write_clip(4095, 4095, 4096, 4096);
            3: write_clip(4000, 3990, 4096, 4096);
            4: write_clip(100, 200, 1, 1);
            default: begin
               p = $urandom_range(0, 9);
               write_clip($urandom_range(0, 4095), $urandom_range(0, 4095),
                          (p < 5) ? $urandom_range(1, 64) :
                          (p < 8) ? $urandom_range(0, 4096) : 4096,
                          (p < 5) ? $urandom_range(1, 64) :
                          (p < 8) ? $urandom_range(0, 4096) : 4096);
            end
         endcase
         random_blits((phase == 1) ? 40 : 150);
         phase++;
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("scaled_clipped_blit_address_gen_unit verification clean");
      end else begin
         $display("scaled_clipped_blit_address_gen_unit verification failed");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #40_000_000;
      $display("scaled_clipped_blit_address_gen_unit verification failed");
      $finish;
   end

endmodule
